FILE: hw/rtl/epdd_pkg.sv
// Shared widths, register indexes, drive codes and reset values for the encoder drive unit.
package epdd_pkg;

  localparam int unsigned PosW    = 32;
  localparam int unsigned DbW     = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  typedef logic signed [PosW-1:0] pos_t;
  typedef logic [DbW-1:0]         db_t;
  typedef logic [1:0]             drive_t;
  typedef logic [CfgIdxW-1:0]     cfg_idx_t;
  typedef logic [CfgDatW-1:0]     cfg_dat_t;

  localparam drive_t DRIVE_HOLD  = 2'd0;
  localparam drive_t DRIVE_OPEN  = 2'd1;
  localparam drive_t DRIVE_CLOSE = 2'd2;

  localparam cfg_idx_t REG_MIN_POSITION = 2'd0;
  localparam cfg_idx_t REG_MAX_POSITION = 2'd1;
  localparam cfg_idx_t REG_DEADBAND     = 2'd2;

  localparam pos_t MIN_POSITION_RST = 32'sd0;
  localparam pos_t MAX_POSITION_RST = 32'sd400;
  localparam db_t  DEADBAND_RST     = 8'd2;

endpackage

FILE: hw/rtl/epdd_if.sv
// Valid/ready channel interfaces for pin samples, results and register writes.
interface epdd_in_if;
  import epdd_pkg::*;
  logic valid;
  logic ready;
  logic clk_level;
  logic dt_level;
  logic zero_level;
  logic control_tick;
  logic in_coast;
  logic override_active;
  logic target_valid;
  pos_t target_value;
  modport source (output valid, output clk_level, output dt_level, output zero_level,
                  output control_tick, output in_coast, output override_active,
                  output target_valid, output target_value, input ready);
  modport sink (input valid, input clk_level, input dt_level, input zero_level,
                input control_tick, input in_coast, input override_active,
                input target_valid, input target_value, output ready);
endinterface

interface epdd_out_if;
  import epdd_pkg::*;
  logic   valid;
  logic   ready;
  drive_t drive;
  pos_t   position;
  pos_t   target;
  modport source (output valid, output drive, output position, output target, input ready);
  modport sink (input valid, input drive, input position, input target, output ready);
endinterface

interface epdd_cfg_if;
  import epdd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t reg_index;
  cfg_dat_t wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hw/rtl/encoder_position_deadband_drive_unit.sv
// Encoder position tracker with clamped target and deadband drive decision.
//
// in_ch carries one beat of pin samples (encoder clock, data, zero button) plus the
// control tick, mode flags and a requested target. Each accepted beat yields exactly
// one beat on out_ch: drive code, encoder position and clamped target after that beat.
// cfg_ch writes min_position, max_position and deadband; it is always ready and is
// meant to be used only while no beat is in flight.
// From in_ch acceptance to out_ch valid a beat passes the input register, then the
// update logic (position step, clamp, error compare) straight into the state
// registers, which also serve as the result register. Throughput is one beat per
// cycle while out_ch is not stalled; the single update stage sets that figure.
// Reset clears position, target, edge history and drive to hold, and loads the
// register defaults 0, 400 and 2.
// When out_ch stalls, the result holds, the input register keeps one more beat, and
// in_ch.ready drops once both are full.
module encoder_position_deadband_drive_unit (
  input  logic clk,
  input  logic rst_n,
  epdd_in_if.sink    in_ch,
  epdd_out_if.source out_ch,
  epdd_cfg_if.sink   cfg_ch
);
  import epdd_pkg::*;

  pos_t min_pos_r;
  pos_t max_pos_r;
  db_t  deadband_r;

  logic in_vld_r;
  logic clk_lvl_r, dt_lvl_r, zero_lvl_r, tick_r, coast_r, ovr_r, tvalid_r;
  pos_t tval_r;

  pos_t   enc_pos_r, enc_pos_nxt;
  pos_t   target_r, target_nxt;
  drive_t drive_r, drive_nxt;
  logic   last_clk_r, clk_seen_r, last_zero_r;
  logic   out_vld_r;

  logic advance;
  logic in_fire;
  pos_t step_pos;
  pos_t sel_target;
  pos_t clamp_hi;
  logic signed [PosW+1:0] diff;
  logic [PosW+1:0]        mag;

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    step_pos = enc_pos_r;
    if (clk_seen_r && (clk_lvl_r != last_clk_r)) begin
      if (dt_lvl_r != clk_lvl_r) begin
        step_pos = enc_pos_r - 32'sd1;
      end else begin
        step_pos = enc_pos_r + 32'sd1;
      end
    end
    enc_pos_nxt = (zero_lvl_r && !last_zero_r) ? '0 : step_pos;

    if (ovr_r || coast_r) begin
      sel_target = tvalid_r ? tval_r : target_r;
    end else begin
      sel_target = '0;
    end
    clamp_hi = (sel_target > max_pos_r) ? max_pos_r : sel_target;
    target_nxt = tick_r ? ((clamp_hi < min_pos_r) ? min_pos_r : clamp_hi) : target_r;

    diff = {{2{enc_pos_nxt[PosW-1]}}, enc_pos_nxt} - {{2{target_nxt[PosW-1]}}, target_nxt};
    mag  = diff[PosW+1] ? (~diff + 1'b1) : diff;
    drive_nxt = drive_r;
    if (tick_r) begin
      if (mag <= {{(PosW+2-DbW){1'b0}}, deadband_r}) begin
        drive_nxt = DRIVE_HOLD;
      end else if (diff[PosW+1]) begin
        drive_nxt = DRIVE_OPEN;
      end else begin
        drive_nxt = DRIVE_CLOSE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pos_r  <= MIN_POSITION_RST;
      max_pos_r  <= MAX_POSITION_RST;
      deadband_r <= DEADBAND_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_MIN_POSITION: min_pos_r  <= pos_t'(cfg_ch.wr_data);
        REG_MAX_POSITION: max_pos_r  <= pos_t'(cfg_ch.wr_data);
        REG_DEADBAND:     deadband_r <= cfg_ch.wr_data[DbW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      clk_lvl_r  <= in_ch.clk_level;
      dt_lvl_r   <= in_ch.dt_level;
      zero_lvl_r <= in_ch.zero_level;
      tick_r     <= in_ch.control_tick;
      coast_r    <= in_ch.in_coast;
      ovr_r      <= in_ch.override_active;
      tvalid_r   <= in_ch.target_valid;
      tval_r     <= in_ch.target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_pos_r   <= '0;
      target_r    <= '0;
      drive_r     <= DRIVE_HOLD;
      last_clk_r  <= 1'b0;
      clk_seen_r  <= 1'b0;
      last_zero_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (advance) begin
        enc_pos_r   <= enc_pos_nxt;
        target_r    <= target_nxt;
        drive_r     <= drive_nxt;
        last_clk_r  <= clk_lvl_r;
        clk_seen_r  <= 1'b1;
        last_zero_r <= zero_lvl_r;
        out_vld_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r   <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.drive    = drive_r;
  assign out_ch.position = enc_pos_r;
  assign out_ch.target   = target_r;

  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (drive_r == DRIVE_HOLD || drive_r == DRIVE_OPEN || drive_r == DRIVE_CLOSE))
    else $error("drive code out of range");

  a_no_tick_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !tick_r) |=> (drive_r == $past(drive_r) && target_r == $past(target_r)))
    else $error("target or drive moved without control tick");

  a_zero_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && zero_lvl_r && !last_zero_r) |=> (enc_pos_r == '0))
    else $error("zero button edge did not clear position");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && tick_r && (min_pos_r <= max_pos_r)) |=>
      (target_r >= $past(min_pos_r) && target_r <= $past(max_pos_r)))
    else $error("target outside limits after tick");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (enc_pos_r == $past(enc_pos_r)))
    else $error("position changed while result stalled");

endmodule
